/* design/rsrd_pkg.sv */
package rsrd_pkg;

  localparam int unsigned MaxPositions = 64;
  localparam int unsigned ClientW      = 7;
  localparam int unsigned ReleaseW     = 20;
  localparam int unsigned ArcW         = 16;
  localparam int unsigned TimeW        = 32;
  // Sum of a 32-bit start time and a 34-bit travel term.
  localparam int unsigned CostW        = 35;
  localparam int unsigned TravelW      = 34;
  localparam int unsigned BaseW        = 33;

  typedef struct packed {
    logic [ClientW-1:0]  client_id;
    logic [ReleaseW-1:0] release_date;
    logic [ArcW-1:0]     arc_from_previous;
    logic [ArcW-1:0]     depot_to_client;
    logic [ArcW-1:0]     client_to_depot;
    logic                last_position;
  } in_item_t;

  typedef struct packed {
    logic [ClientW-1:0] client_out;
    logic [ClientW-1:0] pred_client;
    logic [ClientW-1:0] succ_client;
    logic [TimeW-1:0]   makespan;
    logic               last_result;
  } out_item_t;

  // One tour position as kept in the position memory, without the
  // position of the running maximum release date.
  typedef struct packed {
    logic [ClientW-1:0]  client;
    logic [TimeW-1:0]    prefix;
    logic [ReleaseW-1:0] max_rel;
    logic [ArcW-1:0]     out_time;
    logic [ArcW-1:0]     back_time;
  } pos_row_t;

  typedef struct packed {
    logic clear;
    logic a_en;
    logic i_zero;
  } eval_ctl_t;

  function automatic logic [TimeW-1:0] sat32(input logic [CostW-1:0] v);
    sat32 = (|v[CostW-1:TimeW]) ? '1 : v[TimeW-1:0];
  endfunction

endpackage

/* design/rsrd_ram.sv */
module rsrd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/rsrd_eval.sv */
module rsrd_eval #(
  parameter int unsigned AddrW = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rsrd_pkg::eval_ctl_t                 ctl_i,
  input  logic [AddrW-1:0]                    idx_i,
  input  logic [rsrd_pkg::ReleaseW-1:0]       rel_max_i,
  input  logic [rsrd_pkg::BaseW-1:0]          base_i,
  input  logic [rsrd_pkg::TimeW-1:0]          prefix_i,
  input  logic [rsrd_pkg::ArcW-1:0]           out_time_i,
  input  logic [rsrd_pkg::TimeW-1:0]          prev_best_i,
  output logic [rsrd_pkg::CostW-1:0]          best_o,
  output logic [AddrW-1:0]                    best_start_o
);

  logic [rsrd_pkg::TimeW-1:0]   rel_ext;
  logic [rsrd_pkg::TimeW-1:0]   sigma;
  logic [rsrd_pkg::TravelW-1:0] trav;
  logic [rsrd_pkg::CostW-1:0]   cost;

  logic                         va_q;
  logic [rsrd_pkg::TimeW-1:0]   sig_q;
  logic [rsrd_pkg::TravelW-1:0] trav_q;
  logic [AddrW-1:0]             idx_q;
  logic [rsrd_pkg::CostW-1:0]   best_q;
  logic [AddrW-1:0]             bs_q;

  // First stage: route start time and the travel of the route i..j.
  // The base term already holds the prefix sum at j plus the way back home.
  assign rel_ext = rsrd_pkg::TimeW'(rel_max_i);
  assign sigma   = (!ctl_i.i_zero && (prev_best_i > rel_ext)) ? prev_best_i : rel_ext;
  assign trav    = rsrd_pkg::TravelW'(base_i) - rsrd_pkg::TravelW'(prefix_i)
                 + rsrd_pkg::TravelW'(out_time_i);

  // Second stage: completion time and running minimum, lowest start on a tie.
  assign cost = rsrd_pkg::CostW'(sig_q) + rsrd_pkg::CostW'(trav_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= ctl_i.a_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.a_en) begin
      sig_q  <= sigma;
      trav_q <= trav;
      idx_q  <= idx_i;
    end
    if (ctl_i.clear) begin
      best_q <= '1;
      bs_q   <= '0;
    end else if (va_q && (cost < best_q)) begin
      best_q <= cost;
      bs_q   <= idx_q;
    end
  end

  assign best_o       = best_q;
  assign best_start_o = bs_q;

endmodule

/* design/route_split_release_dates_top.sv */
// Route split with release dates.
// Input channel: one transaction per giant tour position (client, release
// date, arc from the previous client, depot arcs, last marker). While loading,
// a position is taken every cycle. The position marked last, or the one that
// fills the tour, starts the split and in_stall_o stays high until the final
// result of the run has been placed in the output register.
// The split runs one candidate route start per cycle through the position
// memory and the best-makespan memory. For position j it tries the starts 0
// to maxpos(j), where maxpos(j) is the first position of the largest release
// date up to j, and writes the best makespan and its start for j.
// Output channel: n transactions, from the last position down to position
// zero, each giving the client, its predecessor and successor (0 for the
// depot) and the makespan; last_result marks position zero. After the start
// states ST_O0 and ST_O1, each result passes through ST_OQ and ST_OE. A stall
// on the output holds the result register and the sequencer waits for it to drain.
// Accepted items of a new tour may enter while the final result still waits.
// Reset empties the tour and drops any result not yet taken; the memories
// need no clearing since a run only reads entries it has written.
module route_split_release_dates_top #(
  parameter int unsigned MAX_POSITIONS = rsrd_pkg::MaxPositions
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rsrd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsrd_pkg::out_item_t out_data_o
);

  localparam int unsigned AddrW   = $clog2(MAX_POSITIONS);
  localparam int unsigned RowW    = $bits(rsrd_pkg::pos_row_t);
  localparam int unsigned StatW   = RowW + AddrW;
  localparam int unsigned BestW   = rsrd_pkg::TimeW + AddrW;
  localparam logic [AddrW-1:0] LastPos = AddrW'(MAX_POSITIONS - 1);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_RJ   = 4'd1;
  localparam logic [3:0] ST_LJ   = 4'd2;
  localparam logic [3:0] ST_IN   = 4'd3;
  localparam logic [3:0] ST_FIN  = 4'd4;
  localparam logic [3:0] ST_WR   = 4'd5;
  localparam logic [3:0] ST_O0   = 4'd6;
  localparam logic [3:0] ST_O1   = 4'd7;
  localparam logic [3:0] ST_OQ   = 4'd8;
  localparam logic [3:0] ST_OE   = 4'd9;

  logic [3:0] state_q, state_d;

  logic             in_acc;
  logic             is_last;
  logic             out_free;
  logic [AddrW-1:0] p_q;

  // Running values of the tour being loaded.
  logic [rsrd_pkg::TimeW-1:0]    pt_run_q;
  logic [rsrd_pkg::ReleaseW-1:0] mrv_q;
  logic [AddrW-1:0]              mrp_q;
  logic [rsrd_pkg::TimeW-1:0]    pt_new;
  logic [rsrd_pkg::ReleaseW-1:0] mrv_new;
  logic [AddrW-1:0]              mrp_new;
  logic                          take_rel;

  rsrd_pkg::pos_row_t row_w;
  rsrd_pkg::pos_row_t stat_row;
  logic [StatW-1:0]   stat_wdata;
  logic [StatW-1:0]   stat_rdata;
  logic [AddrW-1:0]   stat_raddr;
  logic [AddrW-1:0]   stat_maxpos;

  logic [BestW-1:0]           best_wdata;
  logic [BestW-1:0]           best_rdata;
  logic [AddrW-1:0]           best_raddr;
  logic                       best_we;
  logic [rsrd_pkg::TimeW-1:0] best_rd_time;
  logic [AddrW-1:0]           best_rd_start;

  rsrd_pkg::eval_ctl_t        ctl;
  logic [rsrd_pkg::CostW-1:0] eval_best;
  logic [AddrW-1:0]           eval_start;
  logic [rsrd_pkg::TimeW-1:0] eval_best_sat;

  logic [AddrW-1:0]              j_q;
  logic [AddrW-1:0]              last_q;
  logic [AddrW-1:0]              ia_q;
  logic [AddrW-1:0]              lim_q;
  logic [rsrd_pkg::ReleaseW-1:0] rd_q;
  logic [rsrd_pkg::BaseW-1:0]    base_q;

  logic [AddrW-1:0]                 q_q;
  logic [AddrW-1:0]                 seg_q;
  logic [rsrd_pkg::ClientW-1:0]     cur_q;
  logic [rsrd_pkg::ClientW-1:0]     nxt_q;
  logic                             end_q;
  logic [rsrd_pkg::TimeW-1:0]       makespan_q;
  logic                             out_valid_q;
  rsrd_pkg::out_item_t              out_q;

  assign in_stall_o = (state_q != ST_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_last    = in_data_i.last_position || (p_q == LastPos);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign take_rel = (p_q == '0) || (in_data_i.release_date > mrv_q);
  assign pt_new   = (p_q == '0) ? '0 :
                    rsrd_pkg::sat32(rsrd_pkg::CostW'(pt_run_q)
                                    + rsrd_pkg::CostW'(in_data_i.arc_from_previous));
  assign mrv_new  = take_rel ? in_data_i.release_date : mrv_q;
  assign mrp_new  = take_rel ? p_q : mrp_q;

  always_comb begin
    row_w.client    = in_data_i.client_id;
    row_w.prefix    = pt_new;
    row_w.max_rel   = mrv_new;
    row_w.out_time  = in_data_i.depot_to_client;
    row_w.back_time = in_data_i.client_to_depot;
  end

  assign stat_wdata  = {row_w, mrp_new};
  assign stat_row    = rsrd_pkg::pos_row_t'(stat_rdata[StatW-1:AddrW]);
  assign stat_maxpos = stat_rdata[AddrW-1:0];

  assign best_rd_time  = best_rdata[BestW-1:AddrW];
  assign best_rd_start = best_rdata[AddrW-1:0];
  assign eval_best_sat = rsrd_pkg::sat32(eval_best);
  assign best_wdata    = {eval_best_sat, eval_start};
  assign best_we       = (state_q == ST_WR);

  always_comb begin
    state_d    = state_q;
    stat_raddr = '0;
    best_raddr = '0;
    ctl        = '0;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && is_last) begin
          state_d = ST_RJ;
        end
      end
      ST_RJ: begin
        stat_raddr = j_q;
        state_d    = ST_LJ;
      end
      ST_LJ: begin
        ctl.clear = 1'b1;
        state_d   = ST_IN;
      end
      ST_IN: begin
        // Fetch the next start while the current one is evaluated.
        stat_raddr = ia_q + AddrW'(1);
        best_raddr = ia_q;
        ctl.a_en   = 1'b1;
        ctl.i_zero = (ia_q == '0);
        if (ia_q == lim_q) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_WR;
      end
      ST_WR: begin
        state_d = (j_q == last_q) ? ST_O0 : ST_RJ;
      end
      ST_O0: begin
        stat_raddr = last_q;
        best_raddr = last_q;
        state_d    = ST_O1;
      end
      ST_O1: begin
        state_d = ST_OQ;
      end
      ST_OQ: begin
        stat_raddr = q_q - AddrW'(1);
        best_raddr = q_q - AddrW'(1);
        state_d    = ST_OE;
      end
      ST_OE: begin
        stat_raddr = q_q - AddrW'(1);
        best_raddr = q_q - AddrW'(1);
        if (out_free) begin
          state_d = (q_q == '0) ? ST_LOAD : ST_OQ;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        p_q <= is_last ? '0 : p_q + AddrW'(1);
      end
      if ((state_q == ST_OE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          pt_run_q <= pt_new;
          mrv_q    <= mrv_new;
          mrp_q    <= mrp_new;
          if (is_last) begin
            last_q <= p_q;
            j_q    <= '0;
          end
        end
      end
      ST_LJ: begin
        rd_q   <= stat_row.max_rel;
        base_q <= rsrd_pkg::BaseW'(stat_row.prefix) + rsrd_pkg::BaseW'(stat_row.back_time);
        lim_q  <= (stat_maxpos > j_q) ? j_q : stat_maxpos;
        ia_q   <= '0;
      end
      ST_IN: begin
        if (ia_q != lim_q) begin
          ia_q <= ia_q + AddrW'(1);
        end
      end
      ST_WR: begin
        if (j_q == last_q) begin
          makespan_q <= eval_best_sat;
        end
        j_q <= j_q + AddrW'(1);
      end
      ST_O1: begin
        cur_q <= stat_row.client;
        seg_q <= best_rd_start;
        end_q <= 1'b1;
        q_q   <= last_q;
      end
      ST_OE: begin
        if (out_free) begin
          out_q.client_out  <= cur_q;
          out_q.pred_client <= (q_q == seg_q) ? '0 : stat_row.client;
          out_q.succ_client <= end_q ? '0 : nxt_q;
          out_q.makespan    <= makespan_q;
          out_q.last_result <= (q_q == '0);
          // Walking down: when the current route's head is reached, the
          // position below it ends the previous route.
          nxt_q <= cur_q;
          cur_q <= stat_row.client;
          end_q <= (q_q == seg_q);
          if (q_q == seg_q) begin
            seg_q <= best_rd_start;
          end
          q_q <= q_q - AddrW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  rsrd_ram #(
    .Width(StatW),
    .Depth(MAX_POSITIONS)
  ) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (in_acc),
    .waddr_i(p_q),
    .wdata_i(stat_wdata),
    .raddr_i(stat_raddr),
    .rdata_o(stat_rdata)
  );

  rsrd_ram #(
    .Width(BestW),
    .Depth(MAX_POSITIONS)
  ) u_best_ram (
    .clk_i  (clk_i),
    .we_i   (best_we),
    .waddr_i(j_q),
    .wdata_i(best_wdata),
    .raddr_i(best_raddr),
    .rdata_o(best_rdata)
  );

  rsrd_eval #(
    .AddrW(AddrW)
  ) u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .idx_i       (ia_q),
    .rel_max_i   (rd_q),
    .base_i      (base_q),
    .prefix_i    (stat_row.prefix),
    .out_time_i  (stat_row.out_time),
    .prev_best_i (best_rd_time),
    .best_o      (eval_best),
    .best_start_o(eval_start)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
